### src/one_wire_bus_master_defines.svh
// assertion macros for the one-wire bus master
// each check is sampled on the rising edge of clk and held off during reset
`ifndef ONE_WIRE_BUS_MASTER_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_DEFINES_SVH

`ifndef ASSERT_OFF

`define OWBM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`define OWBM_ASSERT_NEXT(lbl, trig, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error(msg);

`else

`define OWBM_ASSERT(lbl, prop, msg)

`define OWBM_ASSERT_NEXT(lbl, trig, prop, msg)

`endif

`endif

### src/owbm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package owbm_pkg;

	localparam int COUNT_WIDTH = 8;
	localparam int REG_WIDTH = 8;
	localparam int NUM_REGS = 8;
	localparam int REG_IDX_WIDTH = $clog2(NUM_REGS);

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [REG_WIDTH-1:0] timing_t;
	typedef logic [REG_IDX_WIDTH-1:0] reg_idx_t;

	// phase codes
	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_RST_LOW = 3'd1;
	localparam logic [2:0] PH_RST_WAIT = 3'd2;
	localparam logic [2:0] PH_RST_TAIL = 3'd3;
	localparam logic [2:0] PH_SLOT_LOW = 3'd4;
	localparam logic [2:0] PH_SLOT_SAMPLE = 3'd5;
	localparam logic [2:0] PH_SLOT_REST = 3'd6;
	localparam logic [2:0] PH_SLOT_RECOVER = 3'd7;

	// opcodes
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_RESET = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_READ = 2'd3;

	// timing register indexes
	localparam reg_idx_t REG_RESET_LOW = 3'd0;
	localparam reg_idx_t REG_PRESENCE_WAIT = 3'd1;
	localparam reg_idx_t REG_RESET_TAIL = 3'd2;
	localparam reg_idx_t REG_SHORT_LOW = 3'd3;
	localparam reg_idx_t REG_LONG_LOW = 3'd4;
	localparam reg_idx_t REG_READ_SAMPLE = 3'd5;
	localparam reg_idx_t REG_SLOT_REST = 3'd6;
	localparam reg_idx_t REG_RECOVERY = 3'd7;

	localparam timing_t REG_RESET_VALS [NUM_REGS] = '{
		8'd200, 8'd40, 8'd160, 8'd4, 8'd40, 8'd4, 8'd24, 8'd4
	};

	// a zero timing still lasts one tick
	function automatic count_t at_least_one(input timing_t v);
		count_t r;
		r = COUNT_WIDTH'(v);
		if (v == '0) begin
			r = COUNT_WIDTH'(1);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### src/one_wire_bus_master.sv
`timescale 1ns / 1ps
`default_nettype none
// One-wire bus master, stepped by requests on the s_ stream channel.
// s_tuser carries the opcode: tick, bus reset, write byte or read byte.
// s_tdata carries the byte to write and, on ticks, the sampled bus level.
// A command while idle starts an operation; commands while busy are dropped.
// Ticks advance the slot and reset timing, which comes from eight
// registers on the cfg_ port.
// Every request yields exactly one result on the m_ channel: drive_low,
// busy, done pulse, presence level and the last byte read.
// The result of a request is registered and shows on m_ in the cycle after
// it is taken. One request is taken every cycle unless the receiver stalls;
// the state update is one registered pass through the phase and countdown logic.
// The result register frees whenever m_tready is high, so s_tready follows
// m_tready while a result waits; when the receiver stalls the result holds
// and no new request is taken.
// Reset clears the state to idle, presence to one, the read byte to zero and
// loads the default timings. Timing writes must be made only while idle; nothing enforces it.
module one_wire_bus_master (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// request channel
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [15:0]              s_tdata,  // [7:0] data_byte, [8] line_level
	input  wire logic [1:0]               s_tuser,  // [1:0] opcode
	// result channel
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	output logic [15:0]                   m_tdata,  // [0] drive_low, [1] busy_res,
	                                                // [2] done_res, [3] presence_level,
	                                                // [11:4] read_data
	// timing registers
	input  wire logic                     cfg_we,
	input  wire owbm_pkg::reg_idx_t       cfg_addr,
	input  wire owbm_pkg::timing_t        cfg_wdata
);
	import owbm_pkg::*;

	timing_t    regs_q [NUM_REGS];
	logic [2:0] phase_q;
	count_t     cnt_q;
	logic [2:0] bit_cnt_q;
	logic [7:0] shift_q;
	logic [1:0] oper_q;
	logic       pres_q;
	logic [7:0] rd_hold_q;
	logic       m_valid_q;
	logic [15:0] m_data_q;

	logic [2:0] phase_d;
	count_t     cnt_d;
	logic [2:0] bit_cnt_d;
	logic [7:0] shift_d;
	logic [1:0] oper_d;
	logic       pres_d;
	logic [7:0] rd_hold_d;
	logic       done_d;
	logic       enter_rest;
	logic       enter_rec;
	logic       finish_slot;
	logic       accept;

	logic [1:0] in_op;
	logic [7:0] in_data;
	logic       in_level;

	assign in_op = s_tuser;
	assign in_data = s_tdata[7:0];
	assign in_level = s_tdata[8];

	assign s_tready = !m_valid_q || m_tready;
	assign accept = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;

	// timing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= REG_RESET_VALS[i];
			end
		end else if (cfg_we) begin
			regs_q[cfg_addr] <= cfg_wdata;
		end
	end

	// next state for one request
	always_comb begin
		phase_d = phase_q;
		cnt_d = cnt_q;
		bit_cnt_d = bit_cnt_q;
		shift_d = shift_q;
		oper_d = oper_q;
		pres_d = pres_q;
		rd_hold_d = rd_hold_q;
		done_d = 1'b0;
		enter_rest = 1'b0;
		enter_rec = 1'b0;
		finish_slot = 1'b0;

		if (in_op == OP_TICK) begin
			if (phase_q != PH_IDLE) begin
				if (cnt_q > COUNT_WIDTH'(1)) begin
					cnt_d = cnt_q - COUNT_WIDTH'(1);
				end else begin
					case (phase_q)
						PH_RST_LOW: begin
							phase_d = PH_RST_WAIT;
							cnt_d = at_least_one(regs_q[REG_PRESENCE_WAIT]);
						end
						PH_RST_WAIT: begin
							pres_d = in_level;
							if (regs_q[REG_RESET_TAIL] != '0) begin
								phase_d = PH_RST_TAIL;
								cnt_d = COUNT_WIDTH'(regs_q[REG_RESET_TAIL]);
							end else begin
								phase_d = PH_IDLE;
								cnt_d = '0;
								done_d = 1'b1;
							end
						end
						PH_RST_TAIL: begin
							phase_d = PH_IDLE;
							cnt_d = '0;
							done_d = 1'b1;
						end
						PH_SLOT_LOW: begin
							if (oper_q == OP_READ) begin
								phase_d = PH_SLOT_SAMPLE;
								cnt_d = at_least_one(regs_q[REG_READ_SAMPLE]);
							end else if (shift_q[0]) begin
								enter_rest = 1'b1;
							end else begin
								enter_rec = 1'b1;
							end
						end
						PH_SLOT_SAMPLE: begin
							shift_d = {in_level, shift_q[7:1]};
							enter_rest = 1'b1;
						end
						PH_SLOT_REST: begin
							enter_rec = 1'b1;
						end
						PH_SLOT_RECOVER: begin
							finish_slot = 1'b1;
						end
						default: begin
							phase_d = PH_IDLE;
							cnt_d = '0;
						end
					endcase
				end
			end
		end else if (phase_q == PH_IDLE) begin
			oper_d = in_op;
			bit_cnt_d = '0;
			if (in_op == OP_RESET) begin
				phase_d = PH_RST_LOW;
				cnt_d = at_least_one(regs_q[REG_RESET_LOW]);
			end else begin
				shift_d = (in_op == OP_WRITE) ? in_data : 8'h00;
				phase_d = PH_SLOT_LOW;
				if (in_op == OP_READ) begin
					cnt_d = COUNT_WIDTH'(1);
				end else begin
					cnt_d = at_least_one(shift_d[0] ? regs_q[REG_SHORT_LOW]
						: regs_q[REG_LONG_LOW]);
				end
			end
		end

		// rest phase, skipped when its time is zero
		if (enter_rest) begin
			if (regs_q[REG_SLOT_REST] != '0) begin
				phase_d = PH_SLOT_REST;
				cnt_d = COUNT_WIDTH'(regs_q[REG_SLOT_REST]);
			end else begin
				enter_rec = 1'b1;
			end
		end

		// recovery phase, skipped when its time is zero
		if (enter_rec) begin
			if (regs_q[REG_RECOVERY] != '0) begin
				phase_d = PH_SLOT_RECOVER;
				cnt_d = COUNT_WIDTH'(regs_q[REG_RECOVERY]);
			end else begin
				finish_slot = 1'b1;
			end
		end

		// close the bit slot: next bit or end of byte
		if (finish_slot) begin
			if (oper_q != OP_READ) begin
				shift_d = {1'b0, shift_d[7:1]};
			end
			if (bit_cnt_q == 3'd7) begin
				bit_cnt_d = '0;
				if (oper_q == OP_READ) begin
					rd_hold_d = shift_d;
				end
				phase_d = PH_IDLE;
				cnt_d = '0;
				done_d = 1'b1;
			end else begin
				bit_cnt_d = bit_cnt_q + 3'd1;
				phase_d = PH_SLOT_LOW;
				if (oper_q == OP_READ) begin
					cnt_d = COUNT_WIDTH'(1);
				end else begin
					cnt_d = at_least_one(shift_d[0] ? regs_q[REG_SHORT_LOW]
						: regs_q[REG_LONG_LOW]);
				end
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q <= '0;
			bit_cnt_q <= '0;
			shift_q <= '0;
			oper_q <= OP_TICK;
			pres_q <= 1'b1;
			rd_hold_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			cnt_q <= cnt_d;
			bit_cnt_q <= bit_cnt_d;
			shift_q <= shift_d;
			oper_q <= oper_d;
			pres_q <= pres_d;
			rd_hold_q <= rd_hold_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_tready) begin
			m_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_data_q <= {4'h0, rd_hold_d, pres_d, done_d, (phase_d != PH_IDLE),
				((phase_d == PH_RST_LOW) || (phase_d == PH_SLOT_LOW))};
		end
	end

	// checks
`include "one_wire_bus_master_defines.svh"

	`OWBM_ASSERT(a_idle_no_count, (phase_q != PH_IDLE) || (cnt_q == '0), "idle with count left")
	`OWBM_ASSERT(a_bits_in_slot, (bit_cnt_q == '0) || (phase_q >= PH_SLOT_LOW), "bit count outside byte")
	`OWBM_ASSERT(a_done_not_busy, !(m_valid_q && m_data_q[2] && m_data_q[1]), "done while busy")
	`OWBM_ASSERT(a_drive_busy, !(m_valid_q && m_data_q[0] && !m_data_q[1]), "drive low while idle")
	`OWBM_ASSERT_NEXT(a_accept_result, accept, m_valid_q, "request gave no result")

endmodule

`default_nettype wire

### bench/tb_one_wire_bus_master.sv
`timescale 1ns / 1ps

module tb_one_wire_bus_master;
	import owbm_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_REQS = 500;
	localparam int HOLD_CYCLES = 250;
	localparam int DRAIN_CYCLES = 4;

	// one result, packed as on m_tdata, members listed from the top bit down
	typedef struct packed {
		logic [7:0] rd_byte;
		logic       presence;
		logic       done;
		logic       busy;
		logic       drive_low;
	} bus_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // [7:0] data_byte, [8] line_level
	logic [1:0]  s_tuser = '0;   // [1:0] opcode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // [0] drive_low, [1] busy, [2] done, [3] presence,
	                             // [11:4] read_data
	logic        cfg_we = 1'b0;
	reg_idx_t    cfg_addr = '0;
	timing_t     cfg_wdata = '0;

	// line timing predictor state
	timing_t     line_timing [NUM_REGS];
	timing_t     next_timing [NUM_REGS];
	logic [2:0]  ph = PH_IDLE;
	count_t      ticks_left = '0;
	logic [2:0]  bit_idx = '0;
	logic [7:0]  shifter = '0;
	logic [1:0]  cur_op = OP_TICK;
	logic        presence_seen = 1'b1;
	logic [7:0]  byte_read = '0;

	bus_result_t bus_results_due [$];
	int          errors = 0;
	int          reqs_sent = 0;
	int          cycles = 0;
	logic        steady = 1'b0;
	int          pressure_asks = 0;
	int          pressure_served = 0;
	int          hold_left = 0;
	int          stall_left = 0;

	one_wire_bus_master u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_one_wire_bus_master: errors");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// small timings mostly, so that operations finish often
	function automatic timing_t pick_timing();
		int r;
		r = $urandom_range(0, 19);
		if (r < 15) begin
			return timing_t'($urandom_range(0, 4));
		end else if (r < 19) begin
			return timing_t'($urandom_range(5, 12));
		end
		return timing_t'($urandom_range(13, 30));
	endfunction

	function automatic count_t one_or_more(input timing_t v);
		return (v == '0) ? count_t'(1) : count_t'(v);
	endfunction

	// ticks spent in a phase, zero where the phase is skipped
	function automatic count_t phase_ticks(input logic [2:0] p);
		case (p)
			PH_RST_LOW: return one_or_more(line_timing[REG_RESET_LOW]);
			PH_RST_WAIT: return one_or_more(line_timing[REG_PRESENCE_WAIT]);
			PH_RST_TAIL: return count_t'(line_timing[REG_RESET_TAIL]);
			PH_SLOT_LOW: begin
				if (cur_op == OP_READ) begin
					return count_t'(1);
				end
				return one_or_more(shifter[0] ? line_timing[REG_SHORT_LOW]
					: line_timing[REG_LONG_LOW]);
			end
			PH_SLOT_SAMPLE: return one_or_more(line_timing[REG_READ_SAMPLE]);
			PH_SLOT_REST: return count_t'(line_timing[REG_SLOT_REST]);
			PH_SLOT_RECOVER: return count_t'(line_timing[REG_RECOVERY]);
			default: return '0;
		endcase
	endfunction

	// close the running phase and step into the next one that lasts;
	// returns high when the operation has completed
	function automatic logic close_phase(input logic [2:0] first, input logic lvl);
		logic [2:0] p;
		logic [2:0] nx;
		count_t     len;
		logic       settled;
		logic       finished;
		p = first;
		nx = PH_IDLE;
		settled = 1'b0;
		finished = 1'b0;
		while (!settled) begin
			case (p)
				PH_RST_LOW: nx = PH_RST_WAIT;
				PH_RST_WAIT: begin
					presence_seen = lvl;
					nx = PH_RST_TAIL;
				end
				PH_RST_TAIL: begin
					finished = 1'b1;
					settled = 1'b1;
				end
				PH_SLOT_LOW: begin
					if (cur_op == OP_READ) begin
						nx = PH_SLOT_SAMPLE;
					end else begin
						nx = shifter[0] ? PH_SLOT_REST : PH_SLOT_RECOVER;
					end
				end
				PH_SLOT_SAMPLE: begin
					shifter = {lvl, shifter[7:1]};
					nx = PH_SLOT_REST;
				end
				PH_SLOT_REST: nx = PH_SLOT_RECOVER;
				PH_SLOT_RECOVER: begin
					if (cur_op != OP_READ) begin
						shifter = shifter >> 1;
					end
					if (bit_idx == 3'd7) begin
						bit_idx = '0;
						if (cur_op == OP_READ) begin
							byte_read = shifter;
						end
						finished = 1'b1;
						settled = 1'b1;
					end else begin
						bit_idx = bit_idx + 3'd1;
						nx = PH_SLOT_LOW;
					end
				end
				default: settled = 1'b1;
			endcase
			if (settled) begin
				ph = PH_IDLE;
				ticks_left = '0;
			end else begin
				len = phase_ticks(nx);
				if (len != '0) begin
					ph = nx;
					ticks_left = len;
					settled = 1'b1;
				end else begin
					p = nx;
				end
			end
		end
		return finished;
	endfunction

	// next state and result for one accepted request
	function automatic bus_result_t predict_bus(input logic [1:0] op, input logic [7:0] data,
		input logic lvl);
		bus_result_t r;
		logic        fin;
		fin = 1'b0;
		if (op == OP_TICK) begin
			if (ph != PH_IDLE) begin
				if (ticks_left > count_t'(1)) begin
					ticks_left = ticks_left - count_t'(1);
				end else begin
					fin = close_phase(ph, lvl);
				end
			end
		end else if (ph == PH_IDLE) begin
			cur_op = op;
			bit_idx = '0;
			if (op == OP_RESET) begin
				ph = PH_RST_LOW;
			end else begin
				shifter = (op == OP_WRITE) ? data : 8'h00;
				ph = PH_SLOT_LOW;
			end
			ticks_left = phase_ticks(ph);
		end
		r.drive_low = (ph == PH_RST_LOW) || (ph == PH_SLOT_LOW);
		r.busy = (ph != PH_IDLE);
		r.done = fin;
		r.presence = presence_seen;
		r.rd_byte = byte_read;
		return r;
	endfunction

	// offer one request and wait for it to be taken
	task automatic send_req(input logic [1:0] op, input logic [7:0] data, input logic lvl);
		int gap;
		gap = pick_idle();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {7'd0, lvl, data};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		bus_results_due.push_back(predict_bus(op, data, lvl));
		reqs_sent++;
	endtask

	task automatic tick(input logic lvl);
		send_req(OP_TICK, 8'($urandom), lvl);
	endtask

	task automatic tick_until_idle();
		while (ph != PH_IDLE) tick(1'($urandom_range(0, 1)));
	endtask

	// stop offering and let every result come back
	task automatic quiesce();
		s_tvalid <= 1'b0;
		while (bus_results_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write all timing registers, block idle
	task automatic apply_timings();
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_we <= 1'b1;
			cfg_addr <= reg_idx_t'(i);
			cfg_wdata <= next_timing[i];
			@(posedge clk);
			line_timing[i] = next_timing[i];
		end
		cfg_we <= 1'b0;
	endtask

	// receiver: random stalls, plus a long hold-off when asked
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left = hold_left - 1;
		end else if (pressure_asks != pressure_served) begin
			pressure_served = pressure_asks;
			hold_left = HOLD_CYCLES - 1;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left = stall_left - 1;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 5) == 0) begin
				stall_left = pick_idle();
			end
		end
	end

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// compare each result with the oldest one due
	always @(posedge clk) begin : result_check
		bus_result_t seen;
		bus_result_t wanted;
		if (arst_n && m_tvalid && m_tready) begin
			seen = m_tdata[11:0];
			if (bus_results_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0h", $time, seen);
				errors++;
			end else begin
				wanted = bus_results_due.pop_front();
				check_field("drive_low", 8'(wanted.drive_low), 8'(seen.drive_low));
				check_field("busy", 8'(wanted.busy), 8'(seen.busy));
				check_field("done", 8'(wanted.done), 8'(seen.done));
				check_field("presence", 8'(wanted.presence), 8'(seen.presence));
				check_field("read_data", wanted.rd_byte, seen.rd_byte);
			end
		end
	end

	// reset state, then one read byte at the default timings, a reset command sent mid-read
	task automatic test_defaults();
		tick(1'b0);
		tick(1'b1);
		send_req(OP_READ, 8'h5A, 1'b1);
		repeat (40) tick(1'($urandom_range(0, 1)));
		send_req(OP_RESET, 8'h00, 1'b0);
		tick_until_idle();
		quiesce();
	endtask

	// zero everywhere: one-tick phases, skipped rest, tail and recovery
	task automatic test_shortest_timings();
		foreach (next_timing[i]) next_timing[i] = '0;
		apply_timings();
		send_req(OP_RESET, 8'hFF, 1'b1);
		tick(1'b1);
		send_req(OP_WRITE, 8'hAA, 1'b1);
		tick(1'b0);
		tick(1'b1);
		send_req(OP_WRITE, 8'hFF, 1'b1);
		repeat (3) tick(1'b0);
		send_req(OP_READ, 8'h00, 1'b0);
		send_req(OP_RESET, 8'h00, 1'b1);
		tick_until_idle();
		tick(1'b0);
		quiesce();
	endtask

	// full-scale counts: a long reset low, then one long low pulse of each kind
	task automatic test_longest_timings();
		foreach (next_timing[i]) next_timing[i] = 8'hFF;
		next_timing[REG_PRESENCE_WAIT] = 8'h01;
		next_timing[REG_RESET_TAIL] = 8'h01;
		apply_timings();
		send_req(OP_RESET, 8'h00, 1'b0);
		tick_until_idle();
		quiesce();
		next_timing[REG_SHORT_LOW] = 8'hFF;
		next_timing[REG_LONG_LOW] = 8'h01;
		next_timing[REG_SLOT_REST] = 8'h00;
		next_timing[REG_RECOVERY] = 8'h00;
		apply_timings();
		send_req(OP_WRITE, 8'h01, 1'b0);
		tick_until_idle();
		quiesce();
		next_timing[REG_SHORT_LOW] = 8'h01;
		next_timing[REG_LONG_LOW] = 8'hFF;
		apply_timings();
		send_req(OP_WRITE, 8'h7F, 1'b1);
		tick_until_idle();
		quiesce();
	endtask

	// whole operations with random content, stray commands and idle ticks
	task automatic test_random_traffic();
		int first;
		int ops;
		first = reqs_sent;
		ops = 0;
		while (reqs_sent - first < RANDOM_REQS) begin
			if (ops % 6 == 0) begin
				quiesce();
				foreach (next_timing[i]) next_timing[i] = pick_timing();
				apply_timings();
				steady = ($urandom_range(0, 3) == 0);
				if (ops == 0) begin
					// receiver holds off while requests keep coming
					steady = 1'b1;
					pressure_asks++;
				end
			end
			repeat ($urandom_range(0, 2)) tick(1'($urandom_range(0, 1)));
			send_req(2'($urandom_range(OP_RESET, OP_READ)), pick_byte(),
				1'($urandom_range(0, 1)));
			while (ph != PH_IDLE) begin
				if ($urandom_range(0, 15) == 0) begin
					send_req(2'($urandom_range(OP_RESET, OP_READ)), pick_byte(),
						1'($urandom_range(0, 1)));
				end else begin
					tick(1'($urandom_range(0, 1)));
				end
			end
			ops++;
		end
		steady = 1'b0;
		quiesce();
	endtask

	initial begin
		foreach (line_timing[i]) line_timing[i] = REG_RESET_VALS[i];
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_shortest_timings();
		test_longest_timings();
		test_random_traffic();
		if (errors == 0 && bus_results_due.size() == 0) begin
			$display("tb_one_wire_bus_master: clean");
		end else begin
			$display("tb_one_wire_bus_master: errors");
		end
		$finish;
	end

endmodule
